>>> src/timed_event_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// Timed event sequencer assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_EVENT_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define TES_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timed event sequencer port check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define TES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timed event sequencer port check failed");

`endif

>>> src/tes_pkg.sv
// ----------------------------------------------------------------------------
// Timed event sequencer package
// Item codes, register indexes and the structs passed between the modules.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic REG_EVENT_COUNT    = 1'b0;
    localparam logic REG_TICKS_PER_UNIT = 1'b1;

    localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd100;

    // One stored table entry.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] delay;
    } entry_t;

    // Table write request from the engine.
    typedef struct packed {
        logic       we;
        logic [3:0] idx;
        entry_t     data;
    } tbl_wr_t;

    // One result word.
    typedef struct packed {
        logic       shutter_on;
        logic       focus_on;
        logic       busy_res;
        logic       fired;
        logic [1:0] fired_kind;
    } res_t;

endpackage

>>> src/tes_table.sv
// ----------------------------------------------------------------------------
// Timed event sequencer event table
// Single-port write, registered read with write-first bypass.
// ----------------------------------------------------------------------------
module tes_table #(
    parameter int MAX_EVENTS = 16,
    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
    input  logic              aclk,
    input  tes_pkg::tbl_wr_t  wr,
    input  logic [IDX_W-1:0]  rd_addr,
    output tes_pkg::entry_t   rd_entry
);
    import tes_pkg::*;

    entry_t           mem [MAX_EVENTS];
    entry_t           rd_reg;
    logic             wr_ok;
    logic [IDX_W-1:0] wr_addr;

    assign wr_ok   = wr.we && (32'(wr.idx) < MAX_EVENTS);
    assign wr_addr = IDX_W'(wr.idx);

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= wr.data;
        end
        // The read word always tracks the entry at rd_addr, a same-cycle write to it included.
        if (wr_ok && (wr_addr == rd_addr)) begin
            rd_reg <= wr.data;
        end else begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_reg;

endmodule

>>> src/tes_engine.sv
// ----------------------------------------------------------------------------
// Timed event sequencer engine
// Phase machine, delay counter and line levels, one word per cycle while proc is high.
// ----------------------------------------------------------------------------
module tes_engine #(
    parameter int MAX_EVENTS = 16,
    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              proc,
    input  logic [1:0]        op,
    input  logic [3:0]        entry_index,
    input  logic [1:0]        entry_kind,
    input  logic [15:0]       entry_delay,
    input  logic [4:0]        event_count,
    input  logic [15:0]       ticks_per_unit,
    input  tes_pkg::entry_t   rd_entry,
    output tes_pkg::tbl_wr_t  tbl_wr,
    output logic [IDX_W-1:0]  rd_addr,
    output tes_pkg::res_t     res
);
    import tes_pkg::*;

    localparam logic [2:0] PH_INIT  = 3'd0;
    localparam logic [2:0] PH_LOAD  = 3'd1;
    localparam logic [2:0] PH_DELAY = 3'd2;
    localparam logic [2:0] PH_FIRE  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] dc_reg, dc_next;
    logic [1:0]  pk_reg, pk_next;
    logic        shutter_reg, shutter_next;
    logic        focus_reg, focus_next;
    logic        fired;
    logic [1:0]  fired_kind;

    always_comb begin
        logic [2:0]  ph1;
        logic [4:0]  pos1;
        logic [31:0] dc1;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        dc_next      = dc_reg;
        pk_next      = pk_reg;
        shutter_next = shutter_reg;
        focus_next   = focus_reg;
        fired        = 1'b0;
        fired_kind   = 2'd0;
        tbl_wr.we    = 1'b0;
        tbl_wr.idx   = entry_index;
        tbl_wr.data  = '{kind: entry_kind, delay: entry_delay};
        ph1          = phase_reg;
        pos1         = pos_reg;
        dc1          = dc_reg;

        if (proc) begin
            unique case (op)
                OP_TICK: begin
                    // First decide the phase this tick moves to.
                    unique case (phase_reg)
                        PH_INIT: begin
                            ph1  = PH_LOAD;
                            pos1 = 5'd0;
                        end
                        PH_LOAD: begin
                            if (dc_reg <= 32'd1) begin
                                ph1 = PH_FIRE;
                            end else begin
                                dc1 = dc_reg - 32'd1;
                                ph1 = PH_DELAY;
                            end
                        end
                        PH_DELAY: begin
                            if (dc_reg <= 32'd1) begin
                                ph1 = PH_FIRE;
                            end
                        end
                        PH_FIRE: begin
                            if ((32'(pos_reg) >= 32'(event_count)) ||
                                (32'(pos_reg) >= MAX_EVENTS)) begin
                                ph1 = PH_DONE;
                            end else begin
                                ph1 = PH_LOAD;
                            end
                        end
                        PH_DONE: begin
                            ph1 = PH_DONE;
                        end
                        default: begin
                            ph1 = PH_INIT;
                        end
                    endcase

                    phase_next = ph1;
                    pos_next   = pos1;
                    dc_next    = dc1;

                    // Then do the work of the phase just entered.
                    unique case (ph1)
                        PH_INIT: begin
                            pos_next = 5'd0;
                        end
                        PH_LOAD: begin
                            pk_next  = rd_entry.kind;
                            dc_next  = {16'd0, rd_entry.delay} * {16'd0, ticks_per_unit};
                            pos_next = pos1 + 5'd1;
                        end
                        PH_DELAY: begin
                            dc_next = dc1 - 32'd1;
                        end
                        PH_FIRE: begin
                            fired      = 1'b1;
                            fired_kind = pk_reg;
                            case (pk_reg)
                                2'd0:    shutter_next = 1'b1;
                                2'd1:    focus_next   = 1'b1;
                                2'd2:    focus_next   = 1'b0;
                                default: shutter_next = 1'b0;
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
                OP_WRITE: begin
                    tbl_wr.we = 1'b1;
                end
                OP_START: begin
                    phase_next = PH_INIT;
                end
                default: begin
                end
            endcase
        end
    end

    // The table read for the next load: entry 0 after a restart, else the
    // next position, folded back to 0 when it lies past the table.
    always_comb begin
        if (phase_next == PH_INIT) begin
            rd_addr = '0;
        end else if (32'(pos_next) < MAX_EVENTS) begin
            rd_addr = IDX_W'(pos_next);
        end else begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DONE;
            pos_reg     <= 5'd0;
            dc_reg      <= 32'd0;
            pk_reg      <= 2'd0;
            shutter_reg <= 1'b0;
            focus_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            dc_reg      <= dc_next;
            pk_reg      <= pk_next;
            shutter_reg <= shutter_next;
            focus_reg   <= focus_next;
        end
    end

    assign res.shutter_on = shutter_next;
    assign res.focus_on   = focus_next;
    assign res.busy_res   = (phase_next != PH_DONE);
    assign res.fired      = fired;
    assign res.fired_kind = fired_kind;

endmodule

>>> src/timed_event_sequencer_top.sv
// A word taken into the input register passes the engine into the output register.
// Throughput: one word per cycle unless stalled as below; the engine state is updated once per word.
// Both registers hold while a result word waits with m_tready low; an empty
// input register still takes one word in that time.
// Reset (aresetn low, synchronous) empties both registers, puts the machine in
// done with the lines off, and loads event_count 0 and ticks_per_unit 100.
// ----------------------------------------------------------------------------
// Timed event sequencer top level
// Stream ports, configuration registers, input and output registers.
// ----------------------------------------------------------------------------
module timed_event_sequencer_top #(
    parameter int MAX_EVENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // entry_index[3:0], entry_kind[5:4], entry_delay[21:6]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // shutter_on[0], focus_on[1], busy_res[2],
                                   // fired[3], fired_kind[5:4]
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import tes_pkg::*;

    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [3:0]  in_idx_reg;
    logic [1:0]  in_kind_reg;
    logic [15:0] in_delay_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    logic [4:0]  count_reg;
    logic [15:0] tpu_reg;

    logic             adv;
    logic             proc;
    res_t             res;
    tbl_wr_t          tbl_wr;
    entry_t           rd_entry;
    logic [IDX_W-1:0] rd_addr;

    assign adv      = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= 5'd0;
            tpu_reg       <= TICKS_PER_UNIT_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_EVENT_COUNT:    count_reg <= cfg_wdata[4:0];
                    REG_TICKS_PER_UNIT: tpu_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_idx_reg   <= s_tdata[3:0];
            in_kind_reg  <= s_tdata[5:4];
            in_delay_reg <= s_tdata[21:6];
        end
        if (proc) begin
            out_res_reg <= res;
        end
    end

    tes_engine #(
        .MAX_EVENTS(MAX_EVENTS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .proc           (proc),
        .op             (in_op_reg),
        .entry_index    (in_idx_reg),
        .entry_kind     (in_kind_reg),
        .entry_delay    (in_delay_reg),
        .event_count    (count_reg),
        .ticks_per_unit (tpu_reg),
        .rd_entry       (rd_entry),
        .tbl_wr         (tbl_wr),
        .rd_addr        (rd_addr),
        .res            (res)
    );

    tes_table #(
        .MAX_EVENTS(MAX_EVENTS)
    ) u_table (
        .aclk     (aclk),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.fired_kind, out_res_reg.fired,
                       out_res_reg.busy_res, out_res_reg.focus_on, out_res_reg.shutter_on};

endmodule

>>> src/tes_checker.sv
// ----------------------------------------------------------------------------
// Timed event sequencer port checker
// Watches the top-level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
`include "timed_event_sequencer_top_defines.svh"

module tes_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A stalled result word stays put.
    `TES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An event is only fired while the sequence is running.
    `TES_ASSERT_SAME(a_fire_busy, m_tvalid && m_tdata[3], m_tdata[2])

    // Without a fired event the kind field reads zero.
    `TES_ASSERT_SAME(a_kind_idle, m_tvalid && !m_tdata[3], m_tdata[5:4] == 2'd0)

    // A stalled output holds the input side once a word is waiting there too.
    `TES_ASSERT_NEXT(a_in_stall, m_tvalid && !m_tready && s_tvalid && s_tready, !s_tready || m_tready)

endmodule

bind timed_event_sequencer_top tes_checker u_tes_checker (.*);

>>> tb/tes_tb_pkg.sv
// ----------------------------------------------------------------------------
// Timed event sequencer check package
// Line level tracker that mirrors the sequencer and scores its result words.
// ----------------------------------------------------------------------------
package tes_tb_pkg;

    import tes_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] KIND_SHUTTER_ON  = 2'd0;
    localparam logic [1:0] KIND_FOCUS_ON    = 2'd1;
    localparam logic [1:0] KIND_FOCUS_OFF   = 2'd2;
    localparam logic [1:0] KIND_SHUTTER_OFF = 2'd3;

    localparam logic [4:0] TABLE_DEPTH = 5'd16;

    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_LOAD  = 3'd1,
        PH_DELAY = 3'd2,
        PH_FIRE  = 3'd3,
        PH_DONE  = 3'd4
    } engine_phase_e;

    class line_level_tracker;
        logic [4:0]    event_count;
        logic [15:0]   ticks_per_unit;
        engine_phase_e phase;
        logic [4:0]    position;
        logic [31:0]   countdown;
        logic [1:0]    pending_kind;
        logic          shutter;
        logic          focus;
        entry_t        slots [TABLE_DEPTH];
        res_t          levels_due [$];
        int            words_checked;
        int            mismatches;

        function new();
            event_count    = 5'd0;
            ticks_per_unit = TICKS_PER_UNIT_RESET;
            phase          = PH_DONE;
            position       = 5'd0;
            countdown      = 32'd0;
            pending_kind   = 2'd0;
            shutter        = 1'b0;
            focus          = 1'b0;
            words_checked  = 0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic addr, logic [15:0] value);
            if (addr == REG_EVENT_COUNT) begin
                event_count = value[4:0];
            end else begin
                ticks_per_unit = value;
            end
        endfunction

        // One tick of the engine; returns 1 when an event reaches the lines.
        function bit advance();
            logic [4:0] last_pos;
            logic [3:0] slot;
            last_pos = (event_count < TABLE_DEPTH) ? event_count : TABLE_DEPTH;
            case (phase)
                PH_INIT: begin
                    phase    = PH_LOAD;
                    position = 5'd0;
                end
                PH_LOAD: begin
                    if (countdown <= 32'd1) begin
                        phase = PH_FIRE;
                    end else begin
                        countdown = countdown - 32'd1;
                        phase     = PH_DELAY;
                    end
                end
                PH_DELAY: begin
                    if (countdown <= 32'd1) phase = PH_FIRE;
                end
                PH_FIRE: phase = (position >= last_pos) ? PH_DONE : PH_LOAD;
                PH_DONE: ;
                default: phase = PH_INIT;
            endcase

            case (phase)
                PH_INIT: position = 5'd0;
                PH_LOAD: begin
                    slot         = (position < TABLE_DEPTH) ? position[3:0] : 4'd0;
                    pending_kind = slots[slot].kind;
                    countdown    = {16'd0, slots[slot].delay} * {16'd0, ticks_per_unit};
                    position     = position + 5'd1;
                end
                PH_DELAY: countdown = countdown - 32'd1;
                PH_FIRE: begin
                    case (pending_kind)
                        KIND_SHUTTER_ON: shutter = 1'b1;
                        KIND_FOCUS_ON:   focus   = 1'b1;
                        KIND_FOCUS_OFF:  focus   = 1'b0;
                        default:         shutter = 1'b0;
                    endcase
                    return 1'b1;
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        function void note_word(logic [1:0] op, logic [3:0] idx, logic [1:0] kind,
                                logic [15:0] units);
            res_t want;
            want.fired      = 1'b0;
            want.fired_kind = 2'd0;
            case (op)
                OP_TICK: begin
                    if (advance()) begin
                        want.fired      = 1'b1;
                        want.fired_kind = pending_kind;
                    end
                end
                OP_WRITE: begin
                    slots[idx].kind  = kind;
                    slots[idx].delay = units;
                end
                OP_START: phase = PH_INIT;
                default: ;
            endcase
            want.shutter_on = shutter;
            want.focus_on   = focus;
            want.busy_res   = (phase != PH_DONE);
            levels_due.push_back(want);
        endfunction

        function void check_word(res_t got);
            res_t want;
            words_checked++;
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %0d arrived with nothing expected: %p",
                             words_checked, got);
                return;
            end
            want = levels_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %0d mismatch: expected %p, got %p",
                             words_checked, want, got);
            end
        endfunction

        function int outstanding();
            return levels_due.size();
        endfunction
    endclass

endpackage

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Timed event sequencer testbench
// Loads the event table, plays sequences under several count and tick scale
// settings, and scores every result word against a tracked copy of the engine
// while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    import tes_pkg::*;
    import tes_tb_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = '0;

    line_level_tracker levels;

    bit offering   = 1'b0;
    bit gaps_on    = 1'b1;
    int burst_left = 1;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left  = 0;
    int mode       = 0;
    int mode_left  = 0;
    bit ready_next;
    res_t got;

    int unsigned count_plan [13] = '{16, 3, 31, 0, 16, 7, 20, 16, 1, 12, 16, 5, 16};
    int unsigned tpu_plan   [13] = '{1, 2, 1, 1, 65535, 3, 0, 2, 1, 1, 65535, 1, 4};

    always #10 aclk = ~aclk;

    timed_event_sequencer_top #(
        .MAX_EVENTS(16)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    task automatic lower_valid();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offers one word, waits for it to be taken, then paces the next burst.
    task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                             input logic [1:0] kind, input logic [15:0] units);
        s_tvalid <= 1'b1;
        offering = 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, units, kind, idx};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        levels.note_word(op, idx, kind, units);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            if (gaps_on) begin
                lower_valid();
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        lower_valid();
        while (levels.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        levels.write_reg(addr, value);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        #10_000_000;
        $display("** timed_event_sequencer_top: FAILED **");
        $finish;
    end

    // Result side: score each taken word, then pick the next ready level.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                got.shutter_on = m_tdata[0];
                got.focus_on   = m_tdata[1];
                got.busy_res   = m_tdata[2];
                got.fired      = m_tdata[3];
                got.fired_kind = m_tdata[5:4];
                levels.check_word(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (hold_served != hold_asked) begin
                hold_served++;
                hold_left  = 80;
                ready_next = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 120);
                end else begin
                    mode_left--;
                end
                case (mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = ($urandom_range(0, 3) != 0);
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = ~m_tready;
                endcase
            end
            m_tready <= ready_next;
        end
    end

    initial begin
        int          r;
        logic [1:0]  op;
        logic [15:0] units;

        levels = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle engine: the spare op and a tick only report the lines.
        send_word(OP_SPARE, 4'hF, 2'd3, 16'hFFFF);
        send_word(OP_TICK, 4'h0, 2'd0, 16'h0000);

        // Fill the whole table so no later load can hit an unwritten slot.
        for (int i = 0; i < 16; i++)
            send_word(OP_WRITE, 4'(i), 2'(i % 4), (i == 15) ? 16'hFFFF : 16'(i % 3));

        // With the count at zero, entry 0 still loads and fires once.
        drain();
        write_reg(REG_TICKS_PER_UNIT, 16'd1);
        send_word(OP_START, 4'h0, 2'd0, 16'h0000);
        repeat (4) send_word(OP_TICK, 4'h0, 2'd0, 16'h0000);

        for (int p = 0; p < 13; p++) begin
            drain();
            write_reg(REG_EVENT_COUNT, 16'(count_plan[p]));
            write_reg(REG_TICKS_PER_UNIT, 16'(tpu_plan[p]));
            gaps_on = (p % 4 != 2) && (p != 1) && (p != 7);
            // A long receiver hold while words keep coming fills the block.
            if (p == 1 || p == 7) hold_asked <= hold_asked + 1;
            send_word(OP_START, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                      16'($urandom()));
            repeat (95) begin
                r = $urandom_range(0, 99);
                if (r < 3)       op = OP_START;
                else if (r < 15) op = OP_WRITE;
                else if (r < 18) op = OP_SPARE;
                else             op = OP_TICK;
                r = $urandom_range(0, 99);
                if (r < 70)      units = 16'($urandom_range(0, 1));
                else if (r < 90) units = 16'($urandom_range(2, 6));
                else if (r < 97) units = 16'($urandom_range(0, 40));
                else             units = 16'($urandom());
                send_word(op, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), units);
            end
        end

        drain();
        repeat (6) @(posedge aclk);
        if (levels.mismatches == 0 && levels.outstanding() == 0) begin
            $display("** timed_event_sequencer_top: PASSED **");
        end else begin
            $display("** timed_event_sequencer_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/tes_pkg.sv
src/tes_table.sv
src/tes_engine.sv
src/timed_event_sequencer_top.sv
src/tes_checker.sv
tb/tes_tb_pkg.sv
tb/tb.sv
